@@ design/stgcd_pkg.sv @@
package stgcd_pkg;

    localparam int VAL_W = 31;
    localparam int IDX_W = 10;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  left_index;
        logic [IDX_W-1:0]  right_index;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0]  gcd_result;
        logic [STAT_W-1:0] status;
    } t_out_word;

    // front queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        t_op      op;
        t_in_word word;
    } t_fq;

endpackage

@@ design/stgcd_ram.sv @@
module stgcd_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 11264
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/stgcd_gcd.sv @@
module stgcd_gcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [stgcd_pkg::VAL_W-1:0] i_a,
    input  logic [stgcd_pkg::VAL_W-1:0] i_b,
    output logic                       o_done,
    output logic [stgcd_pkg::VAL_W-1:0] o_result
);

    // binary GCD, one step per cycle
    logic                        r_busy;
    logic [stgcd_pkg::VAL_W-1:0] r_a;
    logic [stgcd_pkg::VAL_W-1:0] r_b;
    logic [4:0]                  r_sh;
    logic                        fin;
    logic [stgcd_pkg::VAL_W-1:0] diff_ab;
    logic [stgcd_pkg::VAL_W-1:0] diff_ba;

    assign fin     = (r_a == '0) || (r_b == '0);
    assign diff_ab = r_a - r_b;
    assign diff_ba = r_b - r_a;
    assign o_done  = r_busy && fin;
    assign o_result = (r_a | r_b) << r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_sh <= '0;
        end else if (r_busy && !fin) begin
            if (!r_a[0] && !r_b[0]) begin
                r_a  <= r_a >> 1;
                r_b  <= r_b >> 1;
                r_sh <= r_sh + 5'd1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= diff_ab >> 1;
            end else begin
                r_b <= diff_ba >> 1;
            end
        end
    end

endmodule

@@ design/stgcd_front.sv @@
module stgcd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  stgcd_pkg::t_in_word i_data,
    output stgcd_pkg::t_fq      o_fq,
    input  logic                i_take
);

    stgcd_pkg::t_op      r_op   [2];
    stgcd_pkg::t_in_word r_word [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic                wr;
    logic                rd;
    stgcd_pkg::t_op      op_dec;

    always_comb begin
        unique case (i_data.func)
            stgcd_pkg::FUNC_LOAD:  op_dec = stgcd_pkg::OP_LOAD;
            stgcd_pkg::FUNC_QUERY: op_dec = stgcd_pkg::OP_QUERY;
            stgcd_pkg::FUNC_CLEAR: op_dec = stgcd_pkg::OP_CLEAR;
            default:               op_dec = stgcd_pkg::OP_NONE;
        endcase
    end

    assign full = (r_cnt == 2'd2);
    assign wr   = push && !full;
    assign rd   = i_take && (r_cnt != 2'd0);

    assign o_fq.valid = (r_cnt != 2'd0);
    assign o_fq.op    = r_op[r_rp];
    assign o_fq.word  = r_word[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_op[r_wp]   <= op_dec;
            r_word[r_wp] <= i_data;
        end
    end

endmodule

@@ design/stgcd_back.sv @@
module stgcd_back #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stgcd_pkg::t_fq       i_fq,
    output logic                 o_take,
    input  logic                 pop,
    output logic                 empty,
    output stgcd_pkg::t_out_word o_data
);

    localparam int DEPTH = LEVELS * MAX_ELEMENTS;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int KW = $clog2(LEVELS + 1);
    localparam int LW = stgcd_pkg::IDX_W + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LVL  = 6'b000010,
        S_RDA  = 6'b000100,
        S_RDB  = 6'b001000,
        S_RDW  = 6'b010000,
        S_GCD  = 6'b100000
    } t_state;

    t_state                       r_state;
    logic                         r_isq;
    logic [CW-1:0]                r_count;
    logic [IW-1:0]                r_p;
    logic [KW-1:0]                r_k;
    logic [AW-1:0]                r_addr_a;
    logic [AW-1:0]                r_addr_b;
    logic [AW-1:0]                r_waddr;
    logic [stgcd_pkg::VAL_W-1:0]  r_opa;
    logic                         r_out_valid;
    stgcd_pkg::t_out_word         r_out;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [stgcd_pkg::VAL_W-1:0]  wr_data;
    logic [AW-1:0]                rd_addr;
    logic [stgcd_pkg::VAL_W-1:0]  rd_data;
    logic                         gcd_start;
    logic                         gcd_done;
    logic [stgcd_pkg::VAL_W-1:0]  gcd_res;

    logic [31:0]                  count32;
    logic [31:0]                  left32;
    logic [31:0]                  right32;
    logic [LW-1:0]                qlen;
    logic [KW-1:0]                qk;
    logic [31:0]                  qbase;
    logic                         qbad;
    logic [31:0]                  p1;
    logic [31:0]                  span;
    logic [31:0]                  lstart;
    logic [31:0]                  lbase;
    logic [31:0]                  kbase;
    logic                         lvl_end;

    assign count32 = {{(32-CW){1'b0}}, r_count};
    assign left32  = {{(32-stgcd_pkg::IDX_W){1'b0}}, i_fq.word.left_index};
    assign right32 = {{(32-stgcd_pkg::IDX_W){1'b0}}, i_fq.word.right_index};
    assign qbad    = (left32 > right32) || (right32 >= count32);
    assign qlen    = LW'(right32 - left32 + 32'd1);

    // exponent of the largest power of two within the range length, capped at the top level
    always_comb begin
        qk = '0;
        for (int i = 1; i < LW; i++) begin
            if (i < LEVELS && (qlen >> i) != '0) begin
                qk = KW'(i);
            end
        end
    end
    assign qbase = {{(32-KW){1'b0}}, qk} * MAX_ELEMENTS;

    assign p1      = {{(32-IW){1'b0}}, r_p} + 32'd1;
    assign span    = 32'd1 << r_k;
    assign lvl_end = ({{(32-KW){1'b0}}, r_k} >= LEVELS) || (p1 < span);
    assign lstart  = p1 - span;
    assign kbase   = {{(32-KW){1'b0}}, r_k} * MAX_ELEMENTS;
    assign lbase   = kbase - MAX_ELEMENTS;

    assign o_take = (r_state == S_IDLE) && i_fq.valid && !r_out_valid;
    assign empty  = !r_out_valid;
    assign o_data = r_out;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_waddr;
        wr_data = gcd_res;
        if (o_take && i_fq.op == stgcd_pkg::OP_LOAD && count32 < MAX_ELEMENTS) begin
            wr_en   = 1'b1;
            wr_addr = AW'(count32);
            wr_data = i_fq.word.value;
        end else if (r_state == S_GCD && gcd_done && !r_isq) begin
            wr_en = 1'b1;
        end
    end

    assign rd_addr   = (r_state == S_RDB) ? r_addr_b : r_addr_a;
    assign gcd_start = (r_state == S_RDW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        case (i_fq.op)
                            stgcd_pkg::OP_LOAD: begin
                                if (count32 >= MAX_ELEMENTS) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_LVL;
                                end
                            end
                            stgcd_pkg::OP_QUERY: begin
                                if (qbad) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_RDA;
                                end
                            end
                            stgcd_pkg::OP_CLEAR: begin
                                r_count     <= '0;
                                r_out_valid <= 1'b1;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_LVL: begin
                    if (lvl_end) begin
                        r_count     <= CW'(p1);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_RDA;
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: r_state <= S_RDW;
                S_RDW: r_state <= S_GCD;
                S_GCD: begin
                    if (gcd_done) begin
                        if (r_isq) begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_LVL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RDB) begin
            r_opa <= rd_data;
        end
        if (o_take) begin
            r_isq <= (i_fq.op == stgcd_pkg::OP_QUERY);
            r_p   <= IW'(count32);
            r_k   <= KW'(1);
            r_addr_a <= AW'(qbase + left32);
            r_addr_b <= AW'(qbase + right32 + 32'd1 - (32'd1 << qk));
            r_out.gcd_result <= '0;
            if (i_fq.op == stgcd_pkg::OP_LOAD && count32 >= MAX_ELEMENTS) begin
                r_out.status <= stgcd_pkg::ST_FULL;
            end else if (i_fq.op == stgcd_pkg::OP_QUERY && qbad) begin
                r_out.status <= stgcd_pkg::ST_BAD;
            end else begin
                r_out.status <= stgcd_pkg::ST_OK;
            end
        end
        if (r_state == S_LVL && !lvl_end) begin
            r_addr_a <= AW'(lbase + lstart);
            r_addr_b <= AW'(lbase + lstart + (span >> 1));
            r_waddr  <= AW'(kbase + lstart);
        end
        if (r_state == S_GCD && gcd_done) begin
            if (r_isq) begin
                r_out.gcd_result <= gcd_res;
            end else begin
                r_k <= r_k + KW'(1);
            end
        end
    end

    stgcd_ram #(
        .WIDTH (stgcd_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    stgcd_gcd u_gcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (gcd_start),
        .i_a      (r_opa),
        .i_b      (rd_data),
        .o_done   (gcd_done),
        .o_result (gcd_res)
    );

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !pop |=> r_out_valid)
        else $error("result word dropped before pop");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count32 <= MAX_ELEMENTS)
        else $error("loaded count beyond capacity");

    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GCD && gcd_done && r_isq |=> r_out_valid && r_state == S_IDLE)
        else $error("query finished without a result word");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> !r_out_valid && r_state == S_IDLE)
        else $error("took a word while busy");

endmodule

@@ design/sparse_table_range_gcd.sv @@
// Range-GCD engine on a sparse table held in one single-port-read RAM of
// LEVELS x MAX_ELEMENTS words. Input words pass through a two-entry queue to a
// sequencer that handles one word at a time; a result word waiting to be popped
// holds the sequencer. A clear, an unused code or a rejected word has its
// result word registered at the edge that accepts the input word. A query
// steps through S_RDA, S_RDB and S_RDW for its two RAM reads, then does one
// binary-GCD run in S_GCD (one step per cycle, up to 62 steps for 31-bit
// values). A load writes its value to the RAM as it is accepted, then, for
// each level whose block ends at the new element, does two RAM reads and one
// GCD run and writes the GCD back, for up to LEVELS-1 levels. Loads and queries
// share the one GCD unit and the single RAM read port. There is no clearing pass after reset.
module sparse_table_range_gcd #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  stgcd_pkg::t_in_word  i_data,
    output logic                 empty,
    input  logic                 pop,
    output stgcd_pkg::t_out_word o_data
);

    stgcd_pkg::t_fq fq;
    logic           take;

    stgcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .o_fq    (fq),
        .i_take  (take)
    );

    stgcd_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fq    (fq),
        .o_take  (take),
        .pop     (pop),
        .empty   (empty),
        .o_data  (o_data)
    );

endmodule
